@@ rtl/c8_pkg.sv @@
// shared types, codes and sizes for the chip8 execute unit
`timescale 1ns / 1ps

package c8_pkg;

  // storage sizes
  localparam int MEM_DEPTH    = 4096;
  localparam int MEM_AW       = 12;
  localparam int SCREEN_W     = 64;
  localparam int SCREEN_H     = 32;
  localparam int FB_DEPTH     = SCREEN_W * SCREEN_H;
  localparam int FB_AW        = $clog2(FB_DEPTH);
  localparam int STACK_DEPTH  = 16;
  localparam int STACK_AW     = $clog2(STACK_DEPTH);
  localparam int SP_W         = STACK_AW + 1;

  localparam logic [11:0] START_RESET = 12'd512;

  // operation codes
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_PIXEL = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_EXEC  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  // alu functions
  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SUB  = 3'd1;
  localparam logic [2:0] ALU_OR   = 3'd2;
  localparam logic [2:0] ALU_AND  = 3'd3;
  localparam logic [2:0] ALU_XOR  = 3'd4;
  localparam logic [2:0] ALU_SHR  = 3'd5;
  localparam logic [2:0] ALU_SHL  = 3'd6;
  localparam logic [2:0] ALU_PASS = 3'd7;

  // decimal digit weights
  localparam logic [11:0] BCD_HUND = 12'd100;
  localparam logic [11:0] BCD_TEN  = 12'd10;

  typedef struct packed {
    logic [2:0]  fn;
    logic [11:0] a;
    logic [11:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [11:0] y;
    logic        flag;
    logic        eq;
  } alu_rsp_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] address;
    logic [7:0]  load_data;
    logic [7:0]  key_value;
    logic [7:0]  random_byte;
  } op_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] program_counter_out;
    logic [7:0]  read_data;
    logic        screen_changed;
    logic        sound_active;
    logic [7:0]  delay_value;
  } result_t;

endpackage

@@ rtl/c8_if.sv @@
// channel interfaces: operation in, result out, start address write
`timescale 1ns / 1ps

interface c8_op_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [11:0] address;
  logic [7:0]  load_data;
  logic [7:0]  key_value;
  logic [7:0]  random_byte;
  modport source (output valid, operation, address, load_data, key_value, random_byte,
                  input ready);
  modport sink (input valid, operation, address, load_data, key_value, random_byte,
                output ready);
endinterface

interface c8_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] program_counter_out;
  logic [7:0]  read_data;
  logic        screen_changed;
  logic        sound_active;
  logic [7:0]  delay_value;
  modport source (output valid, status, program_counter_out, read_data, screen_changed,
                  sound_active, delay_value, input ready);
  modport sink (input valid, status, program_counter_out, read_data, screen_changed,
                sound_active, delay_value, output ready);
endinterface

interface c8_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/c8_alu.sv @@
// shared arithmetic, logic, shift and compare unit
`timescale 1ns / 1ps

module c8_alu (
  input  c8_pkg::alu_req_t req,
  output c8_pkg::alu_rsp_t rsp
);
  import c8_pkg::*;

  logic [12:0] sum;
  logic [12:0] dif;

  assign sum = {1'b0, req.a} + {1'b0, req.b};
  assign dif = {1'b0, req.a} - {1'b0, req.b};

  // byte flags come from bit 8 of the sum, the inverted borrow or the shifted-out bit
  always_comb begin
    rsp.eq = (req.a == req.b);
    unique case (req.fn)
      ALU_ADD: begin
        rsp.y = sum[11:0];
        rsp.flag = sum[8];
      end
      ALU_SUB: begin
        rsp.y = dif[11:0];
        rsp.flag = ~dif[12];
      end
      ALU_OR: begin
        rsp.y = req.a | req.b;
        rsp.flag = 1'b0;
      end
      ALU_AND: begin
        rsp.y = req.a & req.b;
        rsp.flag = 1'b0;
      end
      ALU_XOR: begin
        rsp.y = req.a ^ req.b;
        rsp.flag = 1'b0;
      end
      ALU_SHR: begin
        rsp.y = {1'b0, req.b[11:1]};
        rsp.flag = req.b[0];
      end
      ALU_SHL: begin
        rsp.y = {req.b[10:0], 1'b0};
        rsp.flag = req.b[7];
      end
      default: begin
        rsp.y = req.b;
        rsp.flag = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/c8_core.sv @@
// sequencer with memory, frame store, register file, stack and timers
`timescale 1ns / 1ps

module c8_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  c8_pkg::op_item_t in_item,
  input  logic             cfg_we,
  input  logic [11:0]      cfg_pc,
  output logic             done_valid,
  input  logic             done_ready,
  output c8_pkg::result_t  done_item
);
  import c8_pkg::*;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_OP     = 5'd2;
  localparam logic [4:0] S_FETCH2 = 5'd3;
  localparam logic [4:0] S_FETCH3 = 5'd4;
  localparam logic [4:0] S_EXEC   = 5'd5;
  localparam logic [4:0] S_RDQ    = 5'd6;
  localparam logic [4:0] S_WFLAG  = 5'd7;
  localparam logic [4:0] S_DROW   = 5'd8;
  localparam logic [4:0] S_DROWQ  = 5'd9;
  localparam logic [4:0] S_DCOL   = 5'd10;
  localparam logic [4:0] S_DPIX   = 5'd11;
  localparam logic [4:0] S_B100   = 5'd12;
  localparam logic [4:0] S_B10    = 5'd13;
  localparam logic [4:0] S_B1     = 5'd14;
  localparam logic [4:0] S_ST1    = 5'd15;
  localparam logic [4:0] S_LD1    = 5'd16;
  localparam logic [4:0] S_DONE   = 5'd17;

  logic [4:0]  state;
  logic        boot;
  logic [11:0] pc;
  logic [11:0] ir;
  logic [SP_W-1:0] sp;
  logic [SP_W-1:0] sp_m1;
  logic [7:0]  dt;
  logic [7:0]  st;
  logic [15:0] opc;
  op_item_t    item;
  logic [1:0]  status_r;
  logic [7:0]  rd_r;
  logic        changed_r;
  logic [FB_AW-1:0] cnt;
  logic [FB_AW:0]   pix_cnt;
  logic [5:0]  ry;
  logic [6:0]  cx;
  logic [5:0]  px;
  logic [7:0]  rbits;
  logic [3:0]  rcnt;
  logic [3:0]  ccnt;
  logic        coll;
  logic        flag_r;
  logic [7:0]  bval;
  logic [3:0]  dig;
  logic [3:0]  k;

  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  mem_q;
  logic        mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [MEM_AW-1:0] mem_raddr;
  logic [7:0]  mem_wd;

  logic        fb [FB_DEPTH];
  logic        fb_q;
  logic        fb_we;
  logic [FB_AW-1:0] fb_waddr;
  logic [FB_AW-1:0] fb_raddr;
  logic        fb_wd;

  logic [7:0]  vmem [16];
  logic [15:0] vvalid;
  logic [7:0]  va_raw;
  logic [7:0]  vb_raw;
  logic        va_ok;
  logic        vb_ok;
  logic [7:0]  va;
  logic [7:0]  vb;
  logic        v_we;
  logic [3:0]  v_waddr;
  logic [7:0]  v_wd;
  logic [3:0]  vra;
  logic [3:0]  vrb;

  logic [11:0] stack [STACK_DEPTH];

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  logic [3:0]  x;
  logic [3:0]  n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic        draw_end;

  c8_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign x        = opc[11:8];
  assign n        = opc[3:0];
  assign nn       = opc[7:0];
  assign nnn      = opc[11:0];
  assign va       = va_ok ? va_raw : 8'd0;
  assign vb       = vb_ok ? vb_raw : 8'd0;
  assign sp_m1    = sp - SP_W'(1);
  assign draw_end = (rcnt == n) || ry[5];

  assign in_ready   = (state == S_IDLE);
  assign done_valid = (state == S_DONE);
  assign done_item  = '{status: status_r, program_counter_out: pc, read_data: rd_r,
                        screen_changed: changed_r, sound_active: (st != 8'd0),
                        delay_value: dt};

  // port and alu control per sequencer step
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = ir;
    mem_wd = 8'd0;
    mem_raddr = pc;
    fb_we = 1'b0;
    fb_waddr = cnt;
    fb_wd = 1'b0;
    fb_raddr = item.address[FB_AW-1:0];
    v_we = 1'b0;
    v_waddr = x;
    v_wd = 8'd0;
    vra = x;
    vrb = opc[7:4];
    alu_req = '{fn: ALU_PASS, a: 12'd0, b: 12'd0};
    unique case (state)
      S_CLR: begin
        fb_we = 1'b1;
      end
      S_OP: begin
        if (item.operation == OP_LOAD) begin
          mem_we = 1'b1;
          mem_waddr = item.address;
          mem_wd = item.load_data;
        end else if (item.operation == OP_READ) begin
          mem_raddr = item.address;
        end
      end
      S_FETCH2: begin
        mem_raddr = pc + 12'd1;
      end
      S_FETCH3: begin
        vra = (opc[15:12] == 4'hB) ? 4'h0 : opc[11:8];
        vrb = mem_q[7:4];
      end
      S_EXEC: begin
        unique case (opc[15:12])
          4'h3, 4'h4: alu_req = '{fn: ALU_PASS, a: {4'd0, va}, b: {4'd0, nn}};
          4'h5, 4'h9: alu_req = '{fn: ALU_PASS, a: {4'd0, va}, b: {4'd0, vb}};
          4'hE: alu_req = '{fn: ALU_PASS, a: {4'd0, va}, b: {4'd0, item.key_value}};
          4'h6: begin
            v_we = 1'b1;
            v_wd = nn;
          end
          4'h7: begin
            alu_req = '{fn: ALU_ADD, a: {4'd0, va}, b: {4'd0, nn}};
            v_we = 1'b1;
            v_wd = alu_rsp.y[7:0];
          end
          4'h8: begin
            v_wd = alu_rsp.y[7:0];
            unique case (n)
              4'h0: begin
                v_we = 1'b1;
                v_wd = vb;
              end
              4'h1: begin
                alu_req = '{fn: ALU_OR, a: {4'd0, va}, b: {4'd0, vb}};
                v_we = 1'b1;
              end
              4'h2: begin
                alu_req = '{fn: ALU_AND, a: {4'd0, va}, b: {4'd0, vb}};
                v_we = 1'b1;
              end
              4'h3: begin
                alu_req = '{fn: ALU_XOR, a: {4'd0, va}, b: {4'd0, vb}};
                v_we = 1'b1;
              end
              4'h4: begin
                alu_req = '{fn: ALU_ADD, a: {4'd0, va}, b: {4'd0, vb}};
                v_we = 1'b1;
              end
              4'h5: begin
                alu_req = '{fn: ALU_SUB, a: {4'd0, va}, b: {4'd0, vb}};
                v_we = 1'b1;
              end
              4'h6: begin
                alu_req = '{fn: ALU_SHR, a: 12'd0, b: {4'd0, vb}};
                v_we = 1'b1;
              end
              4'h7: begin
                alu_req = '{fn: ALU_SUB, a: {4'd0, vb}, b: {4'd0, va}};
                v_we = 1'b1;
              end
              4'hE: begin
                alu_req = '{fn: ALU_SHL, a: 12'd0, b: {4'd0, vb}};
                v_we = 1'b1;
              end
              default: v_we = 1'b0;
            endcase
          end
          4'hB: alu_req = '{fn: ALU_ADD, a: nnn, b: {4'd0, va}};
          4'hC: begin
            v_we = 1'b1;
            v_wd = item.random_byte & nn;
          end
          4'hF: begin
            unique case (nn)
              8'h07: begin
                v_we = 1'b1;
                v_wd = dt;
              end
              8'h1E: alu_req = '{fn: ALU_ADD, a: ir, b: {4'd0, va}};
              8'h29: alu_req = '{fn: ALU_ADD, a: {2'b0, va, 2'b0}, b: {4'd0, va}};
              8'h55: vra = 4'h0;
              8'h65: mem_raddr = ir;
              default: v_we = 1'b0;
            endcase
          end
          default: v_we = 1'b0;
        endcase
      end
      S_WFLAG: begin
        v_we = 1'b1;
        v_waddr = 4'hF;
        v_wd = {7'd0, flag_r};
      end
      S_DROW: begin
        if (draw_end) begin
          v_we = 1'b1;
          v_waddr = 4'hF;
          v_wd = {7'd0, coll};
        end else begin
          mem_raddr = ir + {8'd0, rcnt};
        end
      end
      S_DCOL: begin
        fb_raddr = {ry[4:0], cx[5:0]};
      end
      S_DPIX: begin
        fb_we = 1'b1;
        fb_waddr = {ry[4:0], cx[5:0]};
        fb_wd = ~fb_q;
      end
      S_B100: begin
        alu_req = '{fn: ALU_SUB, a: {4'd0, bval}, b: BCD_HUND};
        mem_wd = {4'd0, dig};
        mem_we = ~alu_rsp.flag;
      end
      S_B10: begin
        alu_req = '{fn: ALU_SUB, a: {4'd0, bval}, b: BCD_TEN};
        mem_waddr = ir + 12'd1;
        mem_wd = {4'd0, dig};
        mem_we = ~alu_rsp.flag;
      end
      S_B1: begin
        mem_we = 1'b1;
        mem_waddr = ir + 12'd2;
        mem_wd = bval;
      end
      S_ST1: begin
        alu_req = '{fn: ALU_ADD, a: ir, b: {8'd0, x} + 12'd1};
        mem_we = 1'b1;
        mem_waddr = ir + {8'd0, k};
        mem_wd = va;
        vra = k + 4'd1;
      end
      S_LD1: begin
        alu_req = '{fn: ALU_ADD, a: ir, b: {8'd0, x} + 12'd1};
        v_we = 1'b1;
        v_waddr = k;
        v_wd = mem_q;
        mem_raddr = ir + {8'd0, k} + 12'd1;
      end
      default: v_we = 1'b0;
    endcase
  end

  // main memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wd;
    end
    mem_q <= mem[mem_raddr];
  end

  // frame store
  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb[fb_waddr] <= fb_wd;
    end
    fb_q <= fb[fb_raddr];
  end

  // register file, unwritten registers read as zero
  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wd;
    end
    va_raw <= vmem[vra];
    vb_raw <= vmem[vrb];
    va_ok <= vvalid[vra];
    vb_ok <= vvalid[vrb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vvalid <= '0;
    end else if (v_we) begin
      vvalid[v_waddr] <= 1'b1;
    end
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      boot <= 1'b1;
      cnt <= '0;
      pix_cnt <= '0;
      pc <= START_RESET;
      ir <= 12'd0;
      sp <= '0;
      dt <= 8'd0;
      st <= 8'd0;
    end else begin
      unique case (state)
        S_CLR: begin
          cnt <= cnt + FB_AW'(1);
          if (&cnt) begin
            pix_cnt <= '0;
            boot <= 1'b0;
            state <= boot ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            status_r <= ST_OK;
            rd_r <= 8'd0;
            changed_r <= 1'b0;
            state <= S_OP;
          end
        end
        S_OP: begin
          state <= S_DONE;
          if (item.operation == OP_READ || item.operation == OP_PIXEL) begin
            state <= S_RDQ;
          end else if (item.operation == OP_TICK) begin
            if (dt != 8'd0) dt <= dt - 8'd1;
            if (st != 8'd0) st <= st - 8'd1;
          end else if (item.operation == OP_EXEC) begin
            state <= S_FETCH2;
          end
        end
        S_FETCH2: begin
          opc[15:8] <= mem_q;
          state <= S_FETCH3;
        end
        S_FETCH3: begin
          opc[7:0] <= mem_q;
          state <= S_EXEC;
        end
        S_RDQ: begin
          rd_r <= (item.operation == OP_READ) ? mem_q : {7'd0, fb_q};
          state <= S_DONE;
        end
        S_EXEC: begin
          state <= S_DONE;
          unique case (opc[15:12])
            4'h0: begin
              if (opc == 16'h00E0) begin
                pc <= pc + 12'd2;
                changed_r <= (pix_cnt != '0);
                cnt <= '0;
                state <= S_CLR;
              end else if (opc == 16'h00EE) begin
                if (sp == '0) begin
                  status_r <= ST_UNDERFLOW;
                end else begin
                  sp <= sp_m1;
                  pc <= stack[sp_m1[STACK_AW-1:0]] + 12'd2;
                end
              end else begin
                status_r <= ST_UNKNOWN;
              end
            end
            4'h1: pc <= nnn;
            4'h2: begin
              if (sp == SP_W'(STACK_DEPTH)) begin
                status_r <= ST_OVERFLOW;
              end else begin
                stack[sp[STACK_AW-1:0]] <= pc;
                sp <= sp + SP_W'(1);
                pc <= nnn;
              end
            end
            4'h3, 4'h5: pc <= alu_rsp.eq ? pc + 12'd4 : pc + 12'd2;
            4'h4, 4'h9: pc <= alu_rsp.eq ? pc + 12'd2 : pc + 12'd4;
            4'h8: begin
              if (n <= 4'h7 || n == 4'hE) begin
                pc <= pc + 12'd2;
                flag_r <= alu_rsp.flag;
                if (n != 4'h0) state <= S_WFLAG;
              end else begin
                status_r <= ST_UNKNOWN;
              end
            end
            4'hA: begin
              ir <= nnn;
              pc <= pc + 12'd2;
            end
            4'hB: pc <= alu_rsp.y;
            4'hD: begin
              pc <= pc + 12'd2;
              ry <= {1'b0, vb[4:0]};
              px <= va[5:0];
              rcnt <= 4'd0;
              coll <= 1'b0;
              state <= S_DROW;
            end
            4'hE: begin
              if (nn == 8'h9E) begin
                pc <= alu_rsp.eq ? pc + 12'd4 : pc + 12'd2;
              end else if (nn == 8'hA1) begin
                pc <= alu_rsp.eq ? pc + 12'd2 : pc + 12'd4;
              end else begin
                status_r <= ST_UNKNOWN;
              end
            end
            4'hF: begin
              pc <= pc + 12'd2;
              unique case (nn)
                8'h07: dt <= dt;
                8'h15: dt <= va;
                8'h18: st <= va;
                8'h1E, 8'h29: ir <= alu_rsp.y;
                8'h33: begin
                  bval <= va;
                  dig <= 4'd0;
                  state <= S_B100;
                end
                8'h55: begin
                  k <= 4'd0;
                  state <= S_ST1;
                end
                8'h65: begin
                  k <= 4'd0;
                  state <= S_LD1;
                end
                default: begin
                  pc <= pc;
                  status_r <= ST_UNKNOWN;
                end
              endcase
            end
            default: pc <= pc + 12'd2;
          endcase
        end
        S_WFLAG: state <= S_DONE;
        S_DROW: state <= draw_end ? S_DONE : S_DROWQ;
        S_DROWQ: begin
          rbits <= mem_q;
          ccnt <= 4'd0;
          cx <= {1'b0, px};
          state <= S_DCOL;
        end
        S_DCOL: begin
          if (ccnt[3] || cx[6]) begin
            rcnt <= rcnt + 4'd1;
            ry <= ry + 6'd1;
            state <= S_DROW;
          end else if (rbits[7]) begin
            state <= S_DPIX;
          end else begin
            rbits <= {rbits[6:0], 1'b0};
            ccnt <= ccnt + 4'd1;
            cx <= cx + 7'd1;
          end
        end
        S_DPIX: begin
          if (fb_q) begin
            coll <= 1'b1;
            pix_cnt <= pix_cnt - (FB_AW + 1)'(1);
          end else begin
            pix_cnt <= pix_cnt + (FB_AW + 1)'(1);
          end
          changed_r <= 1'b1;
          rbits <= {rbits[6:0], 1'b0};
          ccnt <= ccnt + 4'd1;
          cx <= cx + 7'd1;
          state <= S_DCOL;
        end
        S_B100, S_B10: begin
          if (alu_rsp.flag) begin
            bval <= alu_rsp.y[7:0];
            dig <= dig + 4'd1;
          end else begin
            dig <= 4'd0;
            state <= (state == S_B100) ? S_B10 : S_B1;
          end
        end
        S_B1: state <= S_DONE;
        S_ST1, S_LD1: begin
          if (k == x) begin
            ir <= alu_rsp.y;
            state <= S_DONE;
          end else begin
            k <= k + 4'd1;
          end
        end
        S_DONE: begin
          if (done_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // start address write reloads the program counter
      if (cfg_we) begin
        pc <= cfg_pc;
      end
    end
  end

endmodule

@@ rtl/chip8_instruction_execute_unit.sv @@
// chip8 execute unit top level: channels, result register, checks
`timescale 1ns / 1ps

// Usage:
// op channel carries one item: load byte, read byte, read pixel, timer tick
// or execute one instruction at the program counter. Every item gives one
// result item on the res channel. cfg writes the start address, which also
// loads the program counter; it is always ready.
// Each item runs through the sequencer step by step, with registered memory
// ports; BCD loops over repeated subtractions, block store and load loop per
// register, draw loops per row, column and lit pixel, and clear sweeps the
// whole frame store.
// Result leaves through an output register, so a new item is accepted while
// the last result still waits; a second finished result waits in the core.
// After reset the frame store is swept to zero and op is not ready
// meanwhile; registers are zero, the pc is 512.
// A stalled receiver holds the result stable until it is taken.
module chip8_instruction_execute_unit (
  input logic       clk,
  input logic       rst,
  c8_op_if.sink     op,
  c8_res_if.source  res,
  c8_cfg_if.sink    cfg
);
  import c8_pkg::*;

  op_item_t in_item;
  result_t  done_item;
  result_t  res_q;
  logic     done_valid;
  logic     done_ready;
  logic     res_valid;

  assign in_item = '{operation: op.operation, address: op.address,
                     load_data: op.load_data, key_value: op.key_value,
                     random_byte: op.random_byte};
  assign cfg.ready = 1'b1;

  c8_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (op.valid),
    .in_ready   (op.ready),
    .in_item    (in_item),
    .cfg_we     (cfg.valid),
    .cfg_pc     (cfg.data),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_item  (done_item)
  );

  // output register
  assign done_ready = ~res_valid | res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      res_q <= done_item;
    end
  end

  assign res.valid               = res_valid;
  assign res.status              = res_q.status;
  assign res.program_counter_out = res_q.program_counter_out;
  assign res.read_data           = res_q.read_data;
  assign res.screen_changed      = res_q.screen_changed;
  assign res.sound_active        = res_q.sound_active;
  assign res.delay_value         = res_q.delay_value;

`ifndef SYNTHESIS
  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    op.valid && op.ready |=> !op.ready)
    else $error("item accepted while previous item still in work");

  // frame clearing pass holds off items after reset
  a_boot_clear: assert property (@(posedge clk)
    $fell(rst) |-> !op.ready)
    else $error("item accepted during frame clearing pass");
`endif

endmodule

@@ test/c8_checker.sv @@
// checker for the chip8 execute unit: predicts each result item and compares it
`timescale 1ns / 1ps

module c8_checker (
  input  logic clk,
  input  logic rst,
  c8_op_if     op,
  c8_res_if    res,
  c8_cfg_if    cfg,
  output int   fails,
  output int   waiting
);
  import c8_pkg::*;

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;

  // shadow copy of the core state
  logic [7:0]  mem [MEM_DEPTH];
  logic        pix [FB_DEPTH];
  logic [7:0]  vr [16];
  logic [11:0] iv;
  logic [11:0] pc;
  logic [11:0] calls [STACK_DEPTH];
  int          depth;
  logic [7:0]  dly;
  logic [7:0]  snd;

  result_t result_q[$];

  // execute one instruction at pc, returns the status code
  function automatic logic [1:0] exec_instr(input op_item_t it, inout logic chg);
    logic [15:0] w;
    logic [11:0] nxt, nnn, a;
    logic [7:0]  nn, vx, vy, f, row;
    logic [3:0]  x, y, n;
    int          px, py, p;
    w   = {mem[pc], mem[pc + 12'd1]};
    nnn = w[11:0];
    nn  = w[7:0];
    n   = w[3:0];
    x   = w[11:8];
    y   = w[7:4];
    vx  = vr[x];
    vy  = vr[y];
    nxt = pc + 12'd2;
    case (w[15:12])
      4'h0: begin
        if (w == INS_CLS) begin
          for (int i = 0; i < FB_DEPTH; i++) begin
            if (pix[i]) chg = 1'b1;
            pix[i] = 1'b0;
          end
        end else if (w == INS_RET) begin
          if (depth == 0) return ST_UNDERFLOW;
          depth--;
          nxt = calls[depth] + 12'd2;
        end else begin
          return ST_UNKNOWN;
        end
      end
      4'h1: nxt = nnn;
      4'h2: begin
        if (depth >= STACK_DEPTH) return ST_OVERFLOW;
        calls[depth] = pc;
        depth++;
        nxt = nnn;
      end
      4'h3: if (vx == nn) nxt += 12'd2;
      4'h4: if (vx != nn) nxt += 12'd2;
      4'h5: if (vx == vy) nxt += 12'd2;
      4'h6: vr[x] = nn;
      4'h7: vr[x] = vx + nn;
      4'h8: begin
        case (n)
          4'h0: vr[x] = vy;
          4'h1: begin vr[x] = vx | vy; vr[15] = 8'd0; end
          4'h2: begin vr[x] = vx & vy; vr[15] = 8'd0; end
          4'h3: begin vr[x] = vx ^ vy; vr[15] = 8'd0; end
          4'h4: begin
            f = 8'(({1'b0, vx} + {1'b0, vy}) > 9'd255);
            vr[x] = vx + vy; vr[15] = f;
          end
          4'h5: begin f = 8'(vy <= vx); vr[x] = vx - vy; vr[15] = f; end
          4'h6: begin f = {7'd0, vy[0]}; vr[x] = vy >> 1; vr[15] = f; end
          4'h7: begin f = 8'(vx <= vy); vr[x] = vy - vx; vr[15] = f; end
          4'hE: begin f = {7'd0, vy[7]}; vr[x] = vy << 1; vr[15] = f; end
          default: return ST_UNKNOWN;
        endcase
      end
      4'h9: if (vx != vy) nxt += 12'd2;
      4'hA: iv = nnn;
      4'hB: nxt = {4'd0, vr[0]} + nnn;
      4'hC: vr[x] = it.random_byte & nn;
      4'hD: begin
        // clipped xor draw, vf flags any collision
        px = vx % SCREEN_W;
        py = vy % SCREEN_H;
        vr[15] = 8'd0;
        for (int r = 0; r < n && py + r < SCREEN_H; r++) begin
          a   = iv + 12'(r);
          row = mem[a];
          for (int c = 0; c < 8 && px + c < SCREEN_W; c++) begin
            p = (py + r) * SCREEN_W + px + c;
            if (row[7 - c]) begin
              if (pix[p]) vr[15] = 8'd1;
              pix[p] = ~pix[p];
              chg = 1'b1;
            end
          end
        end
      end
      4'hE: begin
        if (nn == 8'h9E) begin
          if (it.key_value == vx) nxt += 12'd2;
        end else if (nn == 8'hA1) begin
          if (it.key_value != vx) nxt += 12'd2;
        end else begin
          return ST_UNKNOWN;
        end
      end
      default: begin
        case (nn)
          8'h07: vr[x] = dly;
          8'h15: dly = vx;
          8'h18: snd = vx;
          8'h1E: iv = iv + {4'd0, vx};
          8'h29: iv = 12'({4'd0, vx} * 12'd5);
          8'h33: begin
            mem[iv]         = vx / 8'd100;
            mem[iv + 12'd1] = (vx % 8'd100) / 8'd10;
            mem[iv + 12'd2] = vx % 8'd10;
          end
          8'h55: begin
            for (int i = 0; i <= x; i++) mem[iv + 12'(i)] = vr[i];
            iv = iv + {8'd0, x} + 12'd1;
          end
          8'h65: begin
            for (int i = 0; i <= x; i++) vr[i] = mem[iv + 12'(i)];
            iv = iv + {8'd0, x} + 12'd1;
          end
          default: return ST_UNKNOWN;
        endcase
      end
    endcase
    pc = nxt;
    return ST_OK;
  endfunction

  // apply one op item and return the result item it gives
  function automatic result_t predict_result(input op_item_t it);
    result_t r;
    logic    chg;
    r   = '0;
    chg = 1'b0;
    case (it.operation)
      OP_LOAD:  mem[it.address] = it.load_data;
      OP_READ:  r.read_data = mem[it.address];
      OP_PIXEL: r.read_data = {7'd0, pix[it.address[10:0]]};
      OP_TICK: begin
        if (dly != 0) dly--;
        if (snd != 0) snd--;
      end
      OP_EXEC:  r.status = exec_instr(it, chg);
      default: ;
    endcase
    r.program_counter_out = pc;
    r.screen_changed      = chg;
    r.sound_active        = (snd != 0);
    r.delay_value         = dly;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    for (int i = 0; i < MEM_DEPTH; i++) mem[i] = 8'd0;
  end

  assign waiting = result_q.size();

  // watch the channels
  always @(posedge clk) begin
    result_t want;
    op_item_t it;
    if (rst) begin
      for (int i = 0; i < FB_DEPTH; i++) pix[i] = 1'b0;
      for (int i = 0; i < 16; i++) vr[i] = 8'd0;
      iv    = '0;
      pc    = START_RESET;
      depth = 0;
      dly   = '0;
      snd   = '0;
      result_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) pc = cfg.data;
      if (op.valid && op.ready) begin
        it = '{op.operation, op.address, op.load_data, op.key_value, op.random_byte};
        result_q.push_back(predict_result(it));
      end
      if (res.valid && res.ready) begin
        if (result_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fails++;
        end else begin
          want = result_q.pop_front();
          check_field("status", want.status, res.status);
          check_field("program_counter_out", want.program_counter_out,
                      res.program_counter_out);
          check_field("read_data", want.read_data, res.read_data);
          check_field("screen_changed", want.screen_changed, res.screen_changed);
          check_field("sound_active", want.sound_active, res.sound_active);
          check_field("delay_value", want.delay_value, res.delay_value);
        end
      end
    end
  end

endmodule

@@ test/tb_top.sv @@
// testbench top for the chip8 execute unit: stimulus, result stalls, verdict
`timescale 1ns / 1ps

module tb_top;
  import c8_pkg::*;

  logic clk;
  logic rst;
  int   fails;
  int   waiting;
  int   sent;
  int   got;
  int   stall;
  int   stall_draw;
  bit   no_idle;
  logic [11:0] pc_now;

  c8_op_if  op_ch();
  c8_res_if res_ch();
  c8_cfg_if cfg_ch();

  chip8_instruction_execute_unit u_dut (
    .clk (clk),
    .rst (rst),
    .op  (op_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  c8_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .op      (op_ch),
    .res     (res_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .waiting (waiting)
  );

  // clock
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // result side: random stall before each item, tracks pc
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall <= 0;
    end else if (res_ch.valid && res_ch.ready) begin
      got++;
      pc_now = res_ch.program_counter_out;
      stall_draw = no_idle ? 0 : $urandom_range(0, 12);
      stall <= stall_draw;
      res_ch.ready <= (stall_draw == 0);
    end else if (stall > 0) begin
      stall <= stall - 1;
      res_ch.ready <= (stall == 1);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [2:0] o, input logic [11:0] a,
                           input logic [7:0] d, input logic [7:0] k,
                           input logic [7:0] r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_ch.valid       <= 1'b1;
    op_ch.operation   <= o;
    op_ch.address     <= a;
    op_ch.load_data   <= d;
    op_ch.key_value   <= k;
    op_ch.random_byte <= r;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    sent++;
  endtask

  // drop valid and wait until every result has come back
  task automatic wait_idle();
    op_ch.valid <= 1'b0;
    @(posedge clk);
    while (got != sent) @(posedge clk);
  endtask

  // place an instruction at pc and execute it, then wait for its result
  task automatic run_instr(input logic [15:0] w);
    logic [7:0] k;
    k = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    wait_idle();
    send_item(OP_LOAD, pc_now, w[15:8], 8'($urandom), 8'($urandom));
    send_item(OP_LOAD, pc_now + 12'd1, w[7:0], 8'($urandom), 8'($urandom));
    send_item(OP_EXEC, 12'($urandom), 8'($urandom), k, 8'($urandom));
    wait_idle();
  endtask

  task automatic write_start(input logic [11:0] a);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= a;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    pc_now = a;
  endtask

  // random instruction mix, weighted toward well-formed opcodes
  function automatic logic [15:0] pick_instr();
    int          w;
    logic [3:0]  x, y;
    logic [7:0]  nn;
    logic [3:0]  alu_fn [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
    logic [7:0]  f_fn [9] = '{8'h07, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65,
                              8'h0A};
    w  = $urandom_range(0, 99);
    x  = 4'($urandom);
    y  = 4'($urandom);
    nn = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    if (w < 3)  return 16'h00E0;
    if (w < 10) return 16'h00EE;
    if (w < 16) return {4'h2, 12'($urandom)};
    if (w < 21) return {4'h1, 12'($urandom)};
    if (w < 29) return {4'($urandom_range(3, 5)), x, nn} | 16'h0000;
    if (w < 31) return {4'h9, x, y, 4'($urandom)};
    if (w < 40) return {4'h6, x, nn};
    if (w < 45) return {4'h7, x, 8'($urandom)};
    if (w < 60) return {4'h8, x, y, alu_fn[$urandom_range(0, 8)]};
    if (w < 62) return {4'h8, x, y, 4'($urandom)};
    if (w < 66) return {4'hA, 12'($urandom)};
    if (w < 68) return {4'hB, 12'($urandom)};
    if (w < 71) return {4'hC, x, 8'($urandom)};
    if (w < 80) return {4'hD, x, y, 4'($urandom)};
    if (w < 84) return {4'hE, x, $urandom_range(0, 1) ? 8'h9E : 8'hA1};
    if (w < 96) return {4'hF, x, f_fn[$urandom_range(0, 8)]};
    return 16'($urandom);
  endfunction

  task automatic noise_item();
    send_item(3'($urandom), 12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [11:0] starts [4];
    sent = 0;
    got = 0;
    no_idle = 1'b0;
    pc_now = START_RESET;
    op_ch.valid = 1'b0;
    op_ch.operation = OP_LOAD;
    op_ch.address = '0;
    op_ch.load_data = '0;
    op_ch.key_value = '0;
    op_ch.random_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fill all of memory so no fetch or read sees an unwritten byte
    for (int i = 0; i < MEM_DEPTH; i++) begin
      no_idle = (i % 512) < 200;
      send_item(OP_LOAD, 12'(i), 8'($urandom), 8'($urandom), 8'($urandom));
    end
    no_idle = 1'b0;

    // directed: field extremes, unused op codes, error cases
    send_item(OP_LOAD, 12'hFFF, 8'hFF, 8'h00, 8'hFF);
    send_item(OP_READ, 12'hFFF, 8'h00, 8'hFF, 8'h00);
    send_item(OP_READ, 12'h000, 8'h00, 8'h00, 8'h00);
    send_item(OP_PIXEL, 12'hFFF, 8'h00, 8'h00, 8'h00);
    send_item(OP_TICK, 12'h000, 8'h00, 8'h00, 8'h00);
    send_item(3'd5, 12'h555, 8'h00, 8'h00, 8'h00);
    send_item(3'd7, 12'hAAA, 8'h00, 8'h00, 8'h00);
    run_instr(16'h00EE);
    run_instr(16'h0000);
    run_instr(16'hF00A);
    run_instr(16'h6FFF);
    run_instr(16'h8FF6);
    run_instr(16'h8FFE);
    run_instr(16'hA000);
    run_instr(16'hD01F);
    run_instr(16'hD01F);
    run_instr(16'h00E0);
    run_instr(16'hF015);
    run_instr(16'h2ABC);
    run_instr(16'h00EE);

    // random phases over several start addresses, extremes among them
    starts = '{12'h000, 12'hFFF, 12'($urandom), START_RESET};
    for (int ph = 0; ph < 4; ph++) begin
      write_start(starts[ph]);
      for (int g = 0; g < 70; g++) begin
        no_idle = (g >= 30 && g < 40);
        if ($urandom_range(0, 99) < 30) noise_item();
        if (g == 50) begin
          // call storm runs the stack into overflow
          for (int c = 0; c < 18; c++) run_instr({4'h2, 12'($urandom)});
        end else begin
          run_instr(pick_instr());
        end
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
